// ===== src/mpq_pkg.sv =====
package mpq_pkg;

   localparam int PRIO_W = 20;
   localparam int SLOT_W = 8;
   localparam int COORD_W = 32;
   localparam int OCC_W = 9;
   localparam int STATUS_W = 3;
   // slot_x, slot_z, world_x, world_z packed into one memory word
   localparam int DATA_W = 2 * SLOT_W + 2 * COORD_W;

   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DEQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ENQUEUED = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FRESH    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_STALE    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd4;

   typedef struct packed {
      logic                       req_type;
      logic [SLOT_W-1:0]          slot_x;
      logic [SLOT_W-1:0]          slot_z;
      logic signed [COORD_W-1:0]  world_x;
      logic signed [COORD_W-1:0]  world_z;
      logic [PRIO_W-1:0]          priority_req;
      logic signed [COORD_W-1:0]  offset_x;
      logic signed [COORD_W-1:0]  offset_z;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0]        status;
      logic [SLOT_W-1:0]          out_slot_x;
      logic [SLOT_W-1:0]          out_slot_z;
      logic signed [COORD_W-1:0]  out_world_x;
      logic signed [COORD_W-1:0]  out_world_z;
      logic [PRIO_W-1:0]          out_priority;
      logic [OCC_W-1:0]           occupancy;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_FETCH,
      ST_LAST,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic start;
   } scan_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } scan_stat_type;

endpackage

// ===== src/mpq_ram.sv =====
module mpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mpq_min_scan.sv =====
module mpq_min_scan
   import mpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 256,
   localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  scan_ctrl_type     ctrl,
   input  logic [IDX_W-1:0]  last_idx,
   output logic [IDX_W-1:0]  rd_addr,
   input  logic [PRIO_W-1:0] rd_data,
   output scan_stat_type     stat,
   output logic [IDX_W-1:0]  best_idx,
   output logic [PRIO_W-1:0] best_prio
);

   logic              active_ff, active_in;
   logic              issue_ff, issue_in;
   logic              done_ff, done_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         issue_ff  <= 1'b0;
         done_ff   <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         issue_ff  <= issue_in;
         done_ff   <= done_in;
         rd_vld_ff <= rd_vld_in;
      end
      addr_ff      <= addr_in;
      rd_idx_ff    <= rd_idx_in;
      best_idx_ff  <= best_idx_in;
      best_prio_ff <= best_prio_in;
   end

   always_comb begin
      active_in    = active_ff;
      issue_in     = issue_ff;
      done_in      = 1'b0;
      addr_in      = addr_ff;
      rd_vld_in    = issue_ff;
      rd_idx_in    = addr_ff;
      best_idx_in  = best_idx_ff;
      best_prio_in = best_prio_ff;
      if (ctrl.start) begin
         active_in = 1'b1;
         issue_in  = 1'b1;
         addr_in   = '0;
         rd_vld_in = 1'b0;
      end else begin
         // one priority read issued per cycle, compared in the next cycle
         if (issue_ff) begin
            if (addr_ff == last_idx) begin
               issue_in = 1'b0;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         if (rd_vld_ff) begin
            // strict compare keeps the earliest of equal priorities
            if (rd_idx_ff == '0 || rd_data < best_prio_ff) begin
               best_idx_in  = rd_idx_ff;
               best_prio_in = rd_data;
            end
            if (rd_idx_ff == last_idx) begin
               active_in = 1'b0;
               done_in   = 1'b1;
            end
         end
      end
   end

   assign rd_addr   = addr_ff;
   assign stat.busy = active_ff;
   assign stat.done = done_ff;
   assign best_idx  = best_idx_ff;
   assign best_prio = best_prio_ff;

endmodule

// ===== src/min_priority_request_queue.sv =====
// channel  ports                          direction  payload
// req      req_valid req_ready req_data   in         req_payload_type
// rsp      rsp_valid rsp_ready rsp_data   out        rsp_payload_type
//
// one request at a time; req_ready is high only between requests
// enqueue and empty dequeue: answered once the response register is free
// dequeue: a scan through the single read port of the priority memory,
// one entry per cycle, then a fetch of the best and the tail entry
// reset clears state, count and rsp_valid; table memories need no clearing pass
// a response held by rsp_ready stalls the sequencer before any table write
module min_priority_request_queue
   import mpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   req_payload_type   req_ff, req_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;
   logic [DATA_W-1:0] best_data_ff, best_data_in;
   logic [PRIO_W-1:0] last_prio_ff, last_prio_in;

   logic              rsp_load;
   logic              out_free;
   logic              is_full;
   logic              is_empty;
   logic [IDX_W-1:0]  last_idx;
   logic [IDX_W-1:0]  tail_idx;
   logic [CNT_W-1:0]  count_dec;

   logic              prio_we;
   logic [IDX_W-1:0]  prio_wr_addr;
   logic [PRIO_W-1:0] prio_wr_data;
   logic [IDX_W-1:0]  prio_rd_addr;
   logic [PRIO_W-1:0] prio_rd_data;
   logic              data_we;
   logic [IDX_W-1:0]  data_wr_addr;
   logic [DATA_W-1:0] data_wr_data;
   logic [IDX_W-1:0]  data_rd_addr;
   logic [DATA_W-1:0] data_rd_data;

   scan_ctrl_type     scan_ctrl;
   scan_stat_type     scan_stat;
   logic [IDX_W-1:0]  scan_addr;
   logic [IDX_W-1:0]  best_idx;
   logic [PRIO_W-1:0] best_prio;

   logic [SLOT_W-1:0]  best_sx;
   logic [SLOT_W-1:0]  best_sz;
   logic [COORD_W-1:0] best_wx;
   logic [COORD_W-1:0] best_wz;
   logic [COORD_W:0]   diff_x;
   logic [COORD_W:0]   diff_z;
   logic               fresh;

   mpq_ram #(.WIDTH(PRIO_W), .DEPTH(QUEUE_DEPTH)) u_prio_ram (
      .clock   (clock),
      .wr_en   (prio_we),
      .wr_addr (prio_wr_addr),
      .wr_data (prio_wr_data),
      .rd_addr (prio_rd_addr),
      .rd_data (prio_rd_data)
   );

   mpq_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_wr_addr),
      .wr_data (data_wr_data),
      .rd_addr (data_rd_addr),
      .rd_data (data_rd_data)
   );

   mpq_min_scan #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_min_scan (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (scan_ctrl),
      .last_idx  (last_idx),
      .rd_addr   (scan_addr),
      .rd_data   (prio_rd_data),
      .stat      (scan_stat),
      .best_idx  (best_idx),
      .best_prio (best_prio)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      rsp_data_ff  <= rsp_data_in;
      best_data_ff <= best_data_in;
      last_prio_ff <= last_prio_in;
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty  = (count_ff == '0);
   assign count_dec = count_ff - 1'b1;
   assign last_idx  = count_dec[IDX_W-1:0];
   assign tail_idx  = count_ff[IDX_W-1:0];

   assign best_sx = best_data_ff[DATA_W-1 -: SLOT_W];
   assign best_sz = best_data_ff[DATA_W-SLOT_W-1 -: SLOT_W];
   assign best_wx = best_data_ff[2*COORD_W-1 -: COORD_W];
   assign best_wz = best_data_ff[COORD_W-1:0];

   // exact 33-bit differences, so no wraparound can fake a match
   assign diff_x = {best_wx[COORD_W-1], best_wx}
                 - {req_ff.offset_x[COORD_W-1], req_ff.offset_x};
   assign diff_z = {best_wz[COORD_W-1], best_wz}
                 - {req_ff.offset_z[COORD_W-1], req_ff.offset_z};
   assign fresh  = (diff_x == {{(COORD_W+1-SLOT_W){1'b0}}, best_sx})
                && (diff_z == {{(COORD_W+1-SLOT_W){1'b0}}, best_sz});

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      req_in       = req_ff;
      rsp_load     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      best_data_in = best_data_ff;
      last_prio_in = last_prio_ff;
      scan_ctrl    = '0;
      prio_we      = 1'b0;
      prio_wr_addr = tail_idx;
      prio_wr_data = req_ff.priority_req;
      data_we      = 1'b0;
      data_wr_addr = tail_idx;
      data_wr_data = {req_ff.slot_x, req_ff.slot_z, req_ff.world_x, req_ff.world_z};
      prio_rd_addr = scan_addr;
      data_rd_addr = best_idx;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (req_ff.req_type == REQ_ENQUEUE) begin
               if (out_free) begin
                  rsp_load    = 1'b1;
                  rsp_data_in = '0;
                  if (is_full) begin
                     rsp_data_in.status = STATUS_DROPPED;
                  end else begin
                     prio_we  = 1'b1;
                     data_we  = 1'b1;
                     count_in = count_ff + 1'b1;
                     rsp_data_in.status = STATUS_ENQUEUED;
                  end
                  rsp_data_in.occupancy = OCC_W'(count_in);
                  state_in = ST_IDLE;
               end
            end else if (is_empty) begin
               if (out_free) begin
                  rsp_load              = 1'b1;
                  rsp_data_in           = '0;
                  rsp_data_in.status    = STATUS_EMPTY;
                  rsp_data_in.occupancy = OCC_W'(count_in);
                  state_in              = ST_IDLE;
               end
            end else begin
               scan_ctrl.start = 1'b1;
               state_in        = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_stat.done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            data_rd_addr = best_idx;
            prio_rd_addr = last_idx;
            state_in     = ST_LAST;
         end
         ST_LAST: begin
            best_data_in = data_rd_data;
            last_prio_in = prio_rd_data;
            data_rd_addr = last_idx;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            // read port held on the tail entry while the response waits
            data_rd_addr = last_idx;
            if (out_free) begin
               prio_we      = 1'b1;
               prio_wr_addr = best_idx;
               prio_wr_data = last_prio_ff;
               data_we      = 1'b1;
               data_wr_addr = best_idx;
               data_wr_data = data_rd_data;
               count_in     = count_dec;
               rsp_load     = 1'b1;
               rsp_data_in.status       = fresh ? STATUS_FRESH : STATUS_STALE;
               rsp_data_in.out_slot_x   = best_sx;
               rsp_data_in.out_slot_z   = best_sz;
               rsp_data_in.out_world_x  = best_wx;
               rsp_data_in.out_world_z  = best_wz;
               rsp_data_in.out_priority = best_prio;
               rsp_data_in.occupancy    = OCC_W'(count_in);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count beyond table depth");

   a_scan_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_stat.busy |-> state_ff == ST_SCAN)
      else $error("scanner busy outside scan state");

   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_data_in.status == STATUS_ENQUEUED
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("enqueue did not grow the table by one");

   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      rsp_load && (rsp_data_in.status == STATUS_FRESH || rsp_data_in.status == STATUS_STALE)
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("dequeue did not shrink the table by one");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("response loaded over a pending one");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import mpq_pkg::*;

   localparam int QUEUE_DEPTH  = 256;
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int DRAIN_CYCLES = 300;
   localparam int HOLD_CYCLES  = 400;

   typedef enum {AIM_FRESH, AIM_NEAR, AIM_ANY} offset_aim_type;

   typedef struct packed {
      logic [SLOT_W-1:0]         slot_x;
      logic [SLOT_W-1:0]         slot_z;
      logic signed [COORD_W-1:0] world_x;
      logic signed [COORD_W-1:0] world_z;
      logic [PRIO_W-1:0]         prio;
   } held_request_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   // shadow copy of the request table
   held_request_type held_table [QUEUE_DEPTH];
   int               held_count = 0;
   rsp_payload_type  awaited_rsp [$];

   int  failures = 0;
   int  cycle_count = 0;
   bit  req_gaps = 1'b1;
   bit  rsp_gaps = 1'b1;
   int  rsp_hold_len = 0;
   int  rsp_hold_left = 0;

   min_priority_request_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("min_priority_request_queue test failed");
         $finish;
      end
   end

   // first entry with the strictly smallest priority
   function automatic int lowest_entry();
      int best;
      best = 0;
      for (int i = 1; i < held_count; i++) begin
         if (held_table[i].prio < held_table[best].prio) best = i;
      end
      return best;
   endfunction

   function automatic rsp_payload_type serve_request(input req_payload_type r);
      rsp_payload_type  o;
      held_request_type e;
      int               best;
      longint           dx;
      longint           dz;
      o = '0;
      if (r.req_type == REQ_ENQUEUE) begin
         if (held_count >= QUEUE_DEPTH) begin
            o.status = STATUS_DROPPED;
         end else begin
            held_table[held_count] = '{r.slot_x, r.slot_z, r.world_x, r.world_z,
                                       r.priority_req};
            held_count++;
            o.status = STATUS_ENQUEUED;
         end
      end else if (held_count == 0) begin
         o.status = STATUS_EMPTY;
      end else begin
         best = lowest_entry();
         e = held_table[best];
         held_table[best] = held_table[held_count - 1];
         held_count--;
         o.out_slot_x   = e.slot_x;
         o.out_slot_z   = e.slot_z;
         o.out_world_x  = e.world_x;
         o.out_world_z  = e.world_z;
         o.out_priority = e.prio;
         // exact differences, no wraparound
         dx = longint'($signed(e.world_x)) - longint'($signed(r.offset_x));
         dz = longint'($signed(e.world_z)) - longint'($signed(r.offset_z));
         o.status = (dx == longint'(e.slot_x) && dz == longint'(e.slot_z)) ?
                    STATUS_FRESH : STATUS_STALE;
      end
      o.occupancy = held_count[OCC_W-1:0];
      return o;
   endfunction

   function automatic req_payload_type enqueue_req(input logic [SLOT_W-1:0] sx,
                                                   input logic [SLOT_W-1:0] sz,
                                                   input logic [COORD_W-1:0] wx,
                                                   input logic [COORD_W-1:0] wz,
                                                   input logic [PRIO_W-1:0] pr);
      req_payload_type r;
      r.req_type     = REQ_ENQUEUE;
      r.slot_x       = sx;
      r.slot_z       = sz;
      r.world_x      = wx;
      r.world_z      = wz;
      r.priority_req = pr;
      r.offset_x     = $urandom;
      r.offset_z     = $urandom;
      return r;
   endfunction

   // offsets aimed at the entry that the next dequeue will take, unless AIM_ANY
   function automatic req_payload_type dequeue_req(input offset_aim_type aim);
      req_payload_type  r;
      held_request_type e;
      r.req_type     = REQ_DEQUEUE;
      r.slot_x       = $urandom;
      r.slot_z       = $urandom;
      r.world_x      = $urandom;
      r.world_z      = $urandom;
      r.priority_req = $urandom;
      r.offset_x     = $urandom;
      r.offset_z     = $urandom;
      if (held_count != 0 && aim != AIM_ANY) begin
         e = held_table[lowest_entry()];
         r.offset_x = e.world_x - e.slot_x;
         r.offset_z = e.world_z - e.slot_z;
         if (aim == AIM_NEAR) begin
            if ($urandom_range(0, 1)) r.offset_x = r.offset_x + 1;
            else r.offset_z = r.offset_z - 1;
         end
      end
      return r;
   endfunction

   function automatic req_payload_type random_enqueue();
      logic [PRIO_W-1:0] pr;
      // narrow priorities give plenty of ties
      pr = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 20'hFFFFF);
      return enqueue_req($urandom, $urandom, $urandom, $urandom, pr);
   endfunction

   function automatic req_payload_type random_dequeue();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return dequeue_req(AIM_FRESH);
      else if (pick < 85) return dequeue_req(AIM_NEAR);
      else return dequeue_req(AIM_ANY);
   endfunction

   task automatic send_request(input req_payload_type r);
      if (req_gaps && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 50);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_rsp.push_back(serve_request(r));
   endtask

   task automatic wait_until_served();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   // receiver side
   always @(posedge clock) begin
      if (rsp_hold_len != 0) begin
         rsp_hold_left = rsp_hold_len;
         rsp_hold_len = 0;
      end
      if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(rsp_gaps && $urandom_range(0, 99) < 25);
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            $error("response with no request awaiting one");
            failures++;
         end else begin
            want = awaited_rsp.pop_front();
            check_field("status", want.status, rsp_data.status);
            check_field("out_slot_x", want.out_slot_x, rsp_data.out_slot_x);
            check_field("out_slot_z", want.out_slot_z, rsp_data.out_slot_z);
            check_field("out_world_x", want.out_world_x, rsp_data.out_world_x);
            check_field("out_world_z", want.out_world_z, rsp_data.out_world_z);
            check_field("out_priority", want.out_priority, rsp_data.out_priority);
            check_field("occupancy", want.occupancy, rsp_data.occupancy);
         end
      end
   end

   task automatic test_directed();
      send_request(dequeue_req(AIM_ANY));
      send_request(enqueue_req(8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000, 20'hFFFFF));
      send_request(enqueue_req(8'hFF, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000, 20'h00000));
      send_request(enqueue_req(8'hFF, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF, 20'h00000));
      send_request(enqueue_req(8'h00, 8'hFF, 32'd100, -32'sd5, 20'h00000));
      send_request(enqueue_req(8'd12, 8'd34, 32'd1012, -32'sd966, 20'h55555));
      send_request(enqueue_req(8'hAA, 8'h55, 32'hAAAA_AAAA, 32'h5555_5555, 20'hAAAAA));
      // tied zero priorities: earliest position first, wrapping offsets go stale
      send_request(dequeue_req(AIM_FRESH));
      send_request(dequeue_req(AIM_FRESH));
      send_request(dequeue_req(AIM_NEAR));
      send_request(dequeue_req(AIM_FRESH));
      send_request(dequeue_req(AIM_ANY));
      send_request(dequeue_req(AIM_FRESH));
      send_request(dequeue_req(AIM_FRESH));
      send_request(dequeue_req(AIM_ANY));
   endtask

   task automatic test_fill_and_drain();
      repeat (QUEUE_DEPTH + 2) send_request(random_enqueue());
      repeat (QUEUE_DEPTH + 2) send_request(random_dequeue());
   endtask

   task automatic test_random_mix();
      int enq_pct;
      repeat (1000) begin
         if (held_count < 8) enq_pct = 75;
         else if (held_count > 48) enq_pct = 30;
         else enq_pct = 55;
         if ($urandom_range(0, 99) < enq_pct) send_request(random_enqueue());
         else send_request(random_dequeue());
      end
   endtask

   task automatic test_response_stall();
      req_gaps = 1'b0;
      rsp_hold_len = HOLD_CYCLES;
      repeat (60) begin
         if ($urandom_range(0, 99) < 60) send_request(random_enqueue());
         else send_request(random_dequeue());
      end
      req_gaps = 1'b1;
   endtask

   task automatic test_pause_and_burst();
      repeat (40) begin
         if ($urandom_range(0, 99) < 60) send_request(random_enqueue());
         else send_request(random_dequeue());
      end
      wait_until_served();
      // no idling on either side
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      repeat (60) begin
         if ($urandom_range(0, 99) < 50) send_request(random_enqueue());
         else send_request(random_dequeue());
      end
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_and_drain();
      test_random_mix();
      test_response_stall();
      test_pause_and_burst();
      wait_until_served();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("min_priority_request_queue test passed");
      end else begin
         $display("min_priority_request_queue test failed");
      end
      $finish;
   end

endmodule
